@@ rtl/core/upd_pkg.sv @@
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types and constants of the URL percent-decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Most result bytes that one input transaction can cause
  localparam int unsigned MaxRes = 3;
  // Queue depth between front and back, in packets
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);

  // One packet: the result bytes of one input transaction, in order.
  // cnt is 1 to MaxRes; last marks a packet from the final byte of a string.
  typedef struct packed {
    logic [1:0]            cnt;
    logic [MaxRes-1:0][7:0] bytes;
    logic                  last;
  } upd_pkt_t;

  // Push side of the queue
  typedef struct packed {
    logic     push;
    upd_pkt_t pkt;
  } upd_push_t;

  // Head side of the queue
  typedef struct packed {
    logic     avail;
    upd_pkt_t pkt;
  } upd_head_t;

endpackage

@@ rtl/core/upd_if.sv @@
// ----------------------------------------------------------------------------
// upd_in_if / upd_out_if
// Valid/ready channels for encoded input bytes and decoded output bytes.
// ----------------------------------------------------------------------------
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

@@ rtl/core/upd_front.sv @@
// ----------------------------------------------------------------------------
// upd_front
// Accepts encoded bytes, tracks escape state and builds result packets.
// ----------------------------------------------------------------------------
module upd_front
  import upd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  input  logic      q_full_i,
  output upd_push_t push_o
);

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PCT,
    PH_DIG
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       acc;

  function automatic logic is_hex(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] u;
    u = c;
    if (c inside {[8'h30:8'h39]}) begin
      return c[3:0];
    end
    if (c inside {[8'h61:8'h66]}) begin
      u = c - 8'h20;
    end
    return 4'(u - 8'h41 + 8'd10);
  endfunction

  // Result of decoding the current byte from idle
  logic       idle_n;
  logic [7:0] idle_b;
  logic       idle_pct;
  // Bytes emitted ahead of the idle result: 0, 1 ('%') or 2 ('%', held digit)
  logic [1:0] pre_n;
  logic       use_idle;

  assign in_i.ready = !q_full_i;
  assign acc        = in_i.valid && !q_full_i;

  always_comb begin
    idle_pct = (in_i.in_byte == ChPercent) && !in_i.in_last;
    idle_n   = !idle_pct;
    idle_b   = (in_i.in_byte == ChPlus) ? ChSpace : in_i.in_byte;
  end

  always_comb begin
    phase_d        = phase_q;
    held_d         = held_q;
    pre_n          = 2'd0;
    use_idle       = 1'b1;
    push_o.pkt     = '0;
    push_o.pkt.last = in_i.in_last;
    push_o.push    = 1'b0;

    case (phase_q)
      PH_PCT: begin
        pre_n = 2'd1;
        if (is_hex(in_i.in_byte)) begin
          if (!in_i.in_last) begin
            held_d   = in_i.in_byte;
            pre_n    = 2'd0;
            use_idle = 1'b0;
          end
        end
      end
      PH_DIG: begin
        if (!is_hex(in_i.in_byte)) begin
          pre_n = 2'd2;
        end
      end
      default: begin
        pre_n = 2'd0;
      end
    endcase

    push_o.pkt.bytes[0] = ChPercent;
    push_o.pkt.bytes[1] = held_q;
    if (phase_q == PH_DIG && is_hex(in_i.in_byte)) begin
      // Complete escape: one decoded byte
      push_o.pkt.bytes[0] = {hex_val(held_q), hex_val(in_i.in_byte)};
      push_o.pkt.cnt      = 2'd1;
      phase_d             = PH_IDLE;
    end else if (!use_idle) begin
      // Hold first hex digit, nothing to emit
      push_o.pkt.cnt = 2'd0;
      phase_d        = PH_DIG;
    end else begin
      if (phase_q == PH_PCT && is_hex(in_i.in_byte)) begin
        // Final byte after '%': flush both as literals
        push_o.pkt.bytes[1] = in_i.in_byte;
        push_o.pkt.cnt      = 2'd2;
      end else begin
        push_o.pkt.bytes[pre_n] = idle_b;
        push_o.pkt.cnt          = pre_n + {1'b0, idle_n};
      end
      phase_d = idle_pct ? PH_PCT : PH_IDLE;
    end

    if (in_i.in_last) begin
      phase_d = PH_IDLE;
    end
    push_o.push = acc && (push_o.pkt.cnt != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

@@ rtl/core/upd_queue.sv @@
// ----------------------------------------------------------------------------
// upd_queue
// Short packet queue between the front and the back.
// ----------------------------------------------------------------------------
module upd_queue
  import upd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  upd_push_t push_i,
  input  logic      pop_i,
  output logic      full_o,
  output upd_head_t head_o
);

  upd_pkt_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QPtrW:0]   cnt_q;
  logic             do_push, do_pop;

  assign full_o       = (cnt_q == (QPtrW+1)'(QDepth));
  assign head_o.avail = (cnt_q != '0);
  assign head_o.pkt   = mem_q[rd_q];
  assign do_push      = push_i.push && !full_o;
  assign do_pop       = pop_i && head_o.avail;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_i.pkt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/core/upd_back.sv @@
// ----------------------------------------------------------------------------
// upd_back
// Unrolls packets into single output bytes through an output register.
// ----------------------------------------------------------------------------
module upd_back
  import upd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  upd_head_t head_i,
  output logic      pop_o,
  upd_out_if.source out_o
);

  logic [1:0] idx_q;
  logic       ov_q;
  logic [7:0] ob_q;
  logic       ol_q;
  logic       load, at_end;

  assign at_end = (idx_q == head_i.pkt.cnt - 2'd1);
  assign load   = head_i.avail && (!ov_q || out_o.ready);
  assign pop_o  = load && at_end;

  assign out_o.valid    = ov_q;
  assign out_o.out_byte = ob_q;
  assign out_o.out_last = ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ob_q <= head_i.pkt.bytes[idx_q];
      ol_q <= head_i.pkt.last && at_end;
    end
  end

endmodule

@@ rtl/core/url_percent_decoder.sv @@
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming URL percent-decoder with decoupled front end and output back end.
// ----------------------------------------------------------------------------
// Takes one encoded byte per transaction, with in_last on the final byte of
// a string, and returns the decoded bytes, with out_last on the final one.
// "%hh" (either case) becomes one byte, '+' becomes a space, anything else
// passes through; a broken escape is emitted as literal bytes, and pending
// escape bytes are flushed at the end of a string. The front end accepts one
// transaction per cycle while the packet queue (four entries) has room; the
// back end sends one output byte per cycle while the sink is ready, and an
// input byte causes from none to three results. Results pass through the
// queue and the output register.
// ----------------------------------------------------------------------------
module url_percent_decoder
  import upd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  upd_in_if.sink    in_i,
  upd_out_if.source out_o
);

  upd_push_t push;
  upd_head_t head;
  logic      q_full;
  logic      pop;

  // Classify input bytes, track escape state, build packets
  upd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push)
  );

  // Hold packets so front and back can stall independently
  upd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  // Send packet bytes one per transaction
  upd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .out_o  (out_o)
  );

endmodule
